@@ design/sdstk_pkg.sv @@
// Package for the stable descending top-k sorter: word types, field widths
// and register constants shared by the configuration block and the top level.
// Depends on nothing.
package sdstk_pkg;

    localparam int KEY_W      = 16;
    localparam int TAG_W      = 8;
    localparam int KEEP_W     = 6;
    localparam int KEEP_MAX   = 32;
    localparam int KEEP_RESET = 8;

    // Register index of keep_count in the configuration space.
    localparam int REG_KEEP_COUNT = 0;

    typedef struct packed {
        logic [KEY_W-1:0] fitness_key;
        logic [TAG_W-1:0] record_tag;
        logic             batch_end;
    } t_in_word;

    typedef struct packed {
        logic [KEY_W-1:0] ranked_key;
        logic [TAG_W-1:0] ranked_tag;
        logic             rank_last;
        logic             overflowed;
    } t_out_word;

    // One stored record.
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
    } t_entry;

endpackage

@@ design/sdstk_cfg.sv @@
// APB-style configuration register for the top-k sorter (keep_count).
// Depends on sdstk_pkg.
module sdstk_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [2:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output logic [sdstk_pkg::KEEP_W-1:0] o_keep_eff
);

    logic [sdstk_pkg::KEEP_W-1:0] r_keep;
    logic                         sel_keep;

    // Registers are word aligned, so the low address bits select byte lanes only.
    assign sel_keep = (paddr[2] == 1'(sdstk_pkg::REG_KEEP_COUNT));
    assign pready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keep <= sdstk_pkg::KEEP_W'(sdstk_pkg::KEEP_RESET);
        end else if (psel && penable && pwrite && sel_keep) begin
            r_keep <= pwdata[sdstk_pkg::KEEP_W-1:0];
        end
    end

    assign prdata = sel_keep ? {{(32 - sdstk_pkg::KEEP_W){1'b0}}, r_keep} : 32'd0;

    // Zero counts as one and anything above the result limit saturates.
    always_comb begin
        if (r_keep == '0) begin
            o_keep_eff = sdstk_pkg::KEEP_W'(1);
        end else if (r_keep > sdstk_pkg::KEEP_W'(sdstk_pkg::KEEP_MAX)) begin
            o_keep_eff = sdstk_pkg::KEEP_W'(sdstk_pkg::KEEP_MAX);
        end else begin
            o_keep_eff = r_keep;
        end
    end

endmodule

@@ design/sdstk_store.sv @@
// Record store of the top-k sorter: one write port, one read port with
// registered read data. Depends on sdstk_pkg.
module sdstk_store #(
    parameter  int DEPTH = 32,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic                  i_clk,
    input  logic                  i_we,
    input  logic [AW-1:0]         i_waddr,
    input  sdstk_pkg::t_entry     i_wdata,
    input  logic [AW-1:0]         i_raddr,
    output sdstk_pkg::t_entry     o_rdata
);

    sdstk_pkg::t_entry r_mem [DEPTH];
    sdstk_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/stable_descending_sort_top_k_core.sv @@
// Stable descending top-k sorter. Records (16-bit key, 8-bit tag) are taken one
// word per cycle into a record store of MAX_RECORDS entries with one read port and
// one write port; the word with batch_end set is itself a record and closes the
// batch. Records that arrive with the store full are dropped and every result of
// that batch carries overflowed. After the closing word the block stalls its input
// and runs a bubble sort in place over the n stored records: each pass carries one
// record along the store with one read and one write per compare, so the sort
// needs no more than one store read and one store write per cycle. Records
// move only when the later key is strictly greater, so equal keys keep their
// arrival order. The top min(keep_count, n) records are then read out largest
// first at one result word per cycle while the output is not stalled, the final
// one marked with rank_last. keep_count of zero acts as one and values above
// 32 act as 32. The input reopens as soon as the last result is in the output
// register, which drains independently. The store needs no clearing after
// reset, since only entries written in the current batch are read.
module stable_descending_sort_top_k_core #(
    parameter int MAX_RECORDS = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Record input channel.
    input  logic                   i_in_valid,
    input  sdstk_pkg::t_in_word    i_in_word,
    output logic                   o_in_stall,
    // Ranked result channel.
    output logic                   o_out_valid,
    output sdstk_pkg::t_out_word   o_out_word,
    input  logic                   i_out_stall,
    // Configuration port.
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [2:0]             paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    localparam int AW   = $clog2(MAX_RECORDS);
    localparam int CW   = $clog2(MAX_RECORDS + 1);
    localparam int CMPW = (CW > sdstk_pkg::KEEP_W) ? CW : sdstk_pkg::KEEP_W;

    // The sequencer: loading, the four steps of one bubble pass, and readout.
    typedef enum logic [5:0] {
        ST_LOAD  = 6'b000001,
        ST_HEAD  = 6'b000010,
        ST_FIRST = 6'b000100,
        ST_STEP  = 6'b001000,
        ST_TAIL  = 6'b010000,
        ST_EMIT  = 6'b100000
    } t_state;

    t_state                  r_state, n_state;
    logic [CW-1:0]           r_count, n_count;    // records stored this batch
    logic                    r_ovf, n_ovf;        // a record was dropped
    logic [CW-1:0]           r_lim, n_lim;        // compares in the current pass
    logic [AW-1:0]           r_pos, n_pos;        // write position in the pass
    sdstk_pkg::t_entry       r_carry, n_carry;    // record being carried along
    logic [CW-1:0]           r_emit, n_emit;      // results due this batch
    logic [CW-1:0]           r_idx, n_idx;        // next rank to read
    logic                    r_rd_valid, n_rd_valid;
    logic                    r_rd_last, n_rd_last;
    logic [AW-1:0]           r_raddr, n_raddr;
    logic                    r_out_valid, n_out_valid;
    sdstk_pkg::t_out_word    r_out_word, n_out_word;

    logic [sdstk_pkg::KEEP_W-1:0] keep_eff;
    logic                    mem_we;
    logic [AW-1:0]           mem_waddr;
    sdstk_pkg::t_entry       mem_wdata;
    logic [AW-1:0]           mem_raddr;
    sdstk_pkg::t_entry       mem_rdata;

    logic                    in_take;
    logic                    out_take;
    logic                    load_out;
    logic                    issue;
    logic [CW-1:0]           cnt_new;
    logic [CMPW-1:0]         keep_ext;
    logic [CMPW-1:0]         cnt_ext;

    sdstk_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_keep_eff (keep_eff)
    );

    sdstk_store #(
        .DEPTH (MAX_RECORDS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign o_in_stall  = (r_state != ST_LOAD);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    assign in_take  = i_in_valid && (r_state == ST_LOAD);
    assign out_take = r_out_valid && !i_out_stall;
    // The memory read register doubles as a skid stage in front of the output.
    assign load_out = r_rd_valid && (!r_out_valid || out_take);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_ovf       = r_ovf;
        n_lim       = r_lim;
        n_pos       = r_pos;
        n_carry     = r_carry;
        n_emit      = r_emit;
        n_idx       = r_idx;
        n_rd_last   = r_rd_last;
        n_raddr     = r_raddr;
        n_out_valid = r_out_valid;
        n_out_word  = r_out_word;
        mem_we      = 1'b0;
        mem_waddr   = r_pos;
        mem_wdata   = r_carry;
        mem_raddr   = r_raddr;
        issue       = 1'b0;
        cnt_new     = r_count;
        keep_ext    = CMPW'(keep_eff);
        cnt_ext     = '0;

        if (out_take) begin
            n_out_valid = 1'b0;
        end
        if (load_out) begin
            n_out_valid            = 1'b1;
            n_out_word.ranked_key  = mem_rdata.key;
            n_out_word.ranked_tag  = mem_rdata.tag;
            n_out_word.rank_last   = r_rd_last;
            n_out_word.overflowed  = r_ovf;
        end

        unique case (r_state)
            ST_LOAD: begin
                if (in_take) begin
                    if (r_count != CW'(MAX_RECORDS)) begin
                        mem_we        = 1'b1;
                        mem_waddr     = r_count[AW-1:0];
                        mem_wdata.key = i_in_word.fitness_key;
                        mem_wdata.tag = i_in_word.record_tag;
                        cnt_new       = r_count + CW'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    n_count = cnt_new;
                    if (i_in_word.batch_end) begin
                        cnt_ext = CMPW'(cnt_new);
                        n_emit  = (keep_ext < cnt_ext) ? CW'(keep_ext) : cnt_new;
                        n_idx   = '0;
                        if (cnt_new < CW'(2)) begin
                            n_state = ST_EMIT;
                        end else begin
                            n_lim   = cnt_new - CW'(1);
                            n_state = ST_HEAD;
                        end
                    end
                end
            end
            ST_HEAD: begin
                mem_raddr = '0;
                n_raddr   = '0;
                n_pos     = '0;
                n_state   = ST_FIRST;
            end
            ST_FIRST: begin
                n_carry   = mem_rdata;
                mem_raddr = AW'(1);
                n_raddr   = AW'(1);
                n_state   = ST_STEP;
            end
            ST_STEP: begin
                // The later record wins the position only on a strictly greater key.
                mem_we    = 1'b1;
                mem_waddr = r_pos;
                if (mem_rdata.key > r_carry.key) begin
                    mem_wdata = mem_rdata;
                end else begin
                    mem_wdata = r_carry;
                    n_carry   = mem_rdata;
                end
                if ((CW'(r_pos) + CW'(1)) == r_lim) begin
                    n_state = ST_TAIL;
                end else begin
                    n_pos     = r_pos + AW'(1);
                    mem_raddr = r_pos + AW'(2);
                    n_raddr   = r_pos + AW'(2);
                end
            end
            ST_TAIL: begin
                // The carried record is the smallest of this pass and settles here.
                mem_we    = 1'b1;
                mem_waddr = r_lim[AW-1:0];
                mem_wdata = r_carry;
                n_lim     = r_lim - CW'(1);
                n_state   = (r_lim == CW'(1)) ? ST_EMIT : ST_HEAD;
            end
            ST_EMIT: begin
                issue = (r_idx < r_emit) && (!r_rd_valid || load_out);
                if (issue) begin
                    mem_raddr = r_idx[AW-1:0];
                    n_raddr   = r_idx[AW-1:0];
                    n_idx     = r_idx + CW'(1);
                    n_rd_last = ((r_idx + CW'(1)) == r_emit);
                end
                if (load_out && r_rd_last) begin
                    n_count = '0;
                    n_ovf   = 1'b0;
                    n_state = ST_LOAD;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase

        if (issue) begin
            n_rd_valid = 1'b1;
        end else if (load_out) begin
            n_rd_valid = 1'b0;
        end else begin
            n_rd_valid = r_rd_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_rd_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_ovf       <= n_ovf;
            r_rd_valid  <= n_rd_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lim      <= n_lim;
        r_pos      <= n_pos;
        r_carry    <= n_carry;
        r_emit     <= n_emit;
        r_idx      <= n_idx;
        r_rd_last  <= n_rd_last;
        r_raddr    <= n_raddr;
        r_out_word <= n_out_word;
    end

`ifndef SYNTHESIS
    // The fill count never runs past the store.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_RECORDS))
        else $error("record count exceeds store depth");

    // A pending read result exists only while results are being read out.
    a_rd_in_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_valid |-> (r_state == ST_EMIT))
        else $error("pending readout outside emit phase");

    // Every pass of the sort has at least one compare left.
    a_pass_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_HEAD) || (r_state == ST_FIRST) || (r_state == ST_STEP)
            || (r_state == ST_TAIL)) |-> (r_lim != '0))
        else $error("sort pass with no compares");

    // Readout never schedules more ranks than the batch is due.
    a_emit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> (r_idx <= r_emit))
        else $error("readout index past emit count");
`endif

endmodule

@@ tb/sv/sdstk_tb_pkg.sv @@
// Scoreboard for the stable descending top-k sorter testbench: predicts the ranked
// words of each batch and checks the words that the block emits.
// Depends on sdstk_pkg for the word types and field widths.
package sdstk_tb_pkg;

    import sdstk_pkg::*;

    // Record store depth; the block is built with the same value.
    localparam int STORE_DEPTH = 32;

    class rank_scoreboard;

        logic [KEY_W-1:0]  key_mem [STORE_DEPTH];
        logic [TAG_W-1:0]  tag_mem [STORE_DEPTH];
        int unsigned       loaded = 0;
        bit                dropped = 1'b0;
        logic [KEEP_W-1:0] keep_reg = KEEP_W'(KEEP_RESET);
        t_out_word         ranked_q [$];
        int unsigned       fail_count = 0;

        function void set_keep(logic [KEEP_W-1:0] value);
            keep_reg = value;
        endfunction

        function int unsigned pending();
            return ranked_q.size();
        endfunction

        // Takes one accepted record word. A word that closes the batch ranks the
        // stored records and queues the top ones as expected result words.
        function void note_record(t_in_word w);
            int unsigned      limit_n;
            int unsigned      emit_n;
            logic [KEY_W-1:0] k;
            logic [TAG_W-1:0] t;
            t_out_word        r;
            if (loaded < STORE_DEPTH) begin
                key_mem[loaded] = w.fitness_key;
                tag_mem[loaded] = w.record_tag;
                loaded++;
            end else begin
                dropped = 1'b1;
            end
            if (!w.batch_end) return;
            // Bubble passes that move a record only on a strictly greater key,
            // so equal keys stay in arrival order.
            for (int p = 0; p + 1 < loaded; p++) begin
                for (int q = 0; q + 1 < loaded - p; q++) begin
                    if (key_mem[q+1] > key_mem[q]) begin
                        k = key_mem[q];
                        t = tag_mem[q];
                        key_mem[q] = key_mem[q+1];
                        tag_mem[q] = tag_mem[q+1];
                        key_mem[q+1] = k;
                        tag_mem[q+1] = t;
                    end
                end
            end
            if (keep_reg == 0)
                limit_n = 1;
            else if (keep_reg > KEEP_MAX)
                limit_n = KEEP_MAX;
            else
                limit_n = keep_reg;
            emit_n = (limit_n < loaded) ? limit_n : loaded;
            for (int i = 0; i < emit_n; i++) begin
                r.ranked_key = key_mem[i];
                r.ranked_tag = tag_mem[i];
                r.rank_last  = (i + 1 == emit_n);
                r.overflowed = dropped;
                ranked_q.push_back(r);
            end
            loaded  = 0;
            dropped = 1'b0;
        endfunction

        function void check_result(t_out_word got);
            t_out_word want;
            if (ranked_q.size() == 0) begin
                $error("ranked word with none expected: key %0h tag %0h",
                       got.ranked_key, got.ranked_tag);
                fail_count++;
                return;
            end
            want = ranked_q.pop_front();
            if (got.ranked_key !== want.ranked_key) begin
                $error("ranked_key: expected %0h, got %0h", want.ranked_key, got.ranked_key);
                fail_count++;
            end
            if (got.ranked_tag !== want.ranked_tag) begin
                $error("ranked_tag: expected %0h, got %0h", want.ranked_tag, got.ranked_tag);
                fail_count++;
            end
            if (got.rank_last !== want.rank_last) begin
                $error("rank_last: expected %0b, got %0b", want.rank_last, got.rank_last);
                fail_count++;
            end
            if (got.overflowed !== want.overflowed) begin
                $error("overflowed: expected %0b, got %0b", want.overflowed, got.overflowed);
                fail_count++;
            end
        endfunction

    endclass

endpackage

@@ tb/sv/tb_top.sv @@
// Top of the testbench for the stable descending top-k sorter: clock, reset, record
// and result channel drivers, configuration writes and the stimulus sequence.
// Depends on sdstk_pkg and on the scoreboard in sdstk_tb_pkg.
module tb_top;

    import sdstk_pkg::*;
    import sdstk_tb_pkg::*;

    // Generous bound on the whole run; the slowest correct run is far below it.
    localparam int CYCLE_LIMIT = 1000000;
    // Cycles allowed after the last expected word before the run ends or the
    // keep count is rewritten.
    localparam int SETTLE_CYCLES = 20;

    logic        i_clk;
    logic        rst_n;
    logic        in_valid;
    t_in_word    in_word;
    logic        o_in_stall;
    logic        o_out_valid;
    t_out_word   o_out_word;
    logic        out_stall;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int             send_idle_pct;
    int             recv_stall_pct;
    int unsigned    cycle_count;
    rank_scoreboard sb;

    stable_descending_sort_top_k_core #(
        .MAX_RECORDS (STORE_DEPTH)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_word   (in_word),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word),
        .i_out_stall (out_stall),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: a hung handshake or a sort that never finishes ends the run here.
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Result side. Signals are sampled right after the edge, so they still hold
    // the values that the edge saw; a word is taken when valid was high and our
    // stall was low. The stall for the next cycle is drawn once per edge.
    initial begin
        forever begin
            @(posedge i_clk);
            if (rst_n === 1'b1 && o_out_valid === 1'b1 && out_stall === 1'b0)
                sb.check_result(o_out_word);
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Presents one record word, after a random idle gap, and holds it until the
    // block takes it. The next call, or the drain, is what lowers valid, so valid
    // gets at most one assignment per edge.
    task automatic send_record(input t_in_word w);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            in_word  <= t_in_word'($urandom);
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0) @(posedge i_clk);
        sb.note_record(w);
    endtask

    // One APB transfer: setup cycle, access cycle, then a return to idle so that the
    // next transfer does not reassign the strobes at the same edge.
    task automatic apb_transfer(input logic write_en, input logic [31:0] wdata,
                                output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write_en;
        paddr   <= 3'(4 * REG_KEEP_COUNT);
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (pready !== 1'b1) @(posedge i_clk);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // Writes keep_count, tells the scoreboard, and reads the register back.
    task automatic set_keep_count(input logic [KEEP_W-1:0] value);
        logic [31:0] rdata;
        apb_transfer(1'b1, 32'(value), rdata);
        sb.set_keep(value);
        apb_transfer(1'b0, 32'd0, rdata);
        if (rdata[KEEP_W-1:0] !== value) begin
            $error("keep_count: expected %0d, got %0d", value, rdata[KEEP_W-1:0]);
            sb.fail_count++;
        end
    endtask

    // Lowers valid and waits until every expected ranked word has arrived, then
    // lets the block settle so that it is idle for a register write or the end.
    task automatic drain_batches();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Random key with a chosen flavor: full range, a narrow band that makes ties
    // common, the two extremes, or keys crowded near the top.
    function automatic logic [KEY_W-1:0] pick_key(input int flavor);
        case (flavor)
            0: return KEY_W'($urandom);
            1: return KEY_W'($urandom_range(0, 3));
            2: return ($urandom_range(1) != 0) ? {KEY_W{1'b1}} : {KEY_W{1'b0}};
            default: return KEY_W'($urandom_range(16'hFFFF, 16'hFFF0));
        endcase
    endfunction

    // Random batches until about budget record words are sent. Most batches are
    // short; some run past the store size so that the extra records are dropped,
    // and a dropped record may well be the one that closes the batch.
    task automatic run_batches(input int budget, input bit big_first);
        int       sent;
        int       size;
        int       roll;
        int       flavor;
        t_in_word w;
        sent = 0;
        while (sent < budget) begin
            roll = $urandom_range(99);
            if (sent == 0 && big_first)
                size = 34;
            else if (roll < 10)
                size = $urandom_range(STORE_DEPTH + 6, STORE_DEPTH - 1);
            else if (roll < 14)
                size = $urandom_range(STORE_DEPTH + 1, STORE_DEPTH);
            else
                size = $urandom_range(10, 1);
            flavor = $urandom_range(3);
            for (int i = 0; i < size; i++) begin
                w.fitness_key = pick_key(($urandom_range(9) == 0) ? 0 : flavor);
                w.record_tag  = TAG_W'($urandom);
                w.batch_end   = (i == size - 1);
                send_record(w);
            end
            sent += size;
        end
    endtask

    task automatic run_phase(input logic [KEEP_W-1:0] keep, input int send_pct,
                             input int recv_pct, input int budget, input bit big_first);
        set_keep_count(keep);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        run_batches(budget, big_first);
        drain_batches();
    endtask

    task automatic send_directed(input logic [KEY_W-1:0] key, input logic [TAG_W-1:0] tag,
                                 input logic closes);
        t_in_word w;
        w.fitness_key = key;
        w.record_tag  = tag;
        w.batch_end   = closes;
        send_record(w);
    endtask

    initial begin
        sb = new;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_word   = '0;
        out_stall = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;

        repeat (6) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, at the reset keep count of eight and with no idling.
        // A batch of one record, with the largest key and tag.
        send_directed(16'hFFFF, 8'hFF, 1'b1);
        // Extremes and a tie: the two equal keys must come out in arrival order.
        send_directed(16'h0000, 8'h00, 1'b0);
        send_directed(16'hFFFF, 8'h01, 1'b0);
        send_directed(16'h8000, 8'h02, 1'b0);
        send_directed(16'h8000, 8'h03, 1'b0);
        send_directed(16'h0001, 8'h04, 1'b1);
        // All keys equal and fewer records than the keep count: every record is
        // emitted, unchanged in order.
        for (int i = 0; i < 6; i++)
            send_directed(16'h1234, TAG_W'(8'h10 + i), i == 5);
        // Ascending keys force the most swaps; only the top eight of ten come out.
        for (int i = 0; i < 10; i++)
            send_directed(KEY_W'(16'h0100 * i + 16'h00AA), TAG_W'(8'h80 + i), i == 9);
        drain_batches();

        // Random phases: keep count extremes, zero that acts as one, values above
        // the result limit, and every mix of sender gaps and result stalls.
        run_phase(6'd1,  0,  0,  30, 1'b0);
        run_phase(6'd32, 74, 0,  55, 1'b1);
        run_phase(6'd0,  0,  74, 40, 1'b0);
        run_phase(6'd63, 38, 38, 65, 1'b1);
        run_phase(6'd33, 0,  0,  45, 1'b0);
        run_phase(KEEP_W'($urandom_range(31, 2)), 74, 74, 55, 1'b0);

        if (sb.pending() != 0) begin
            $error("%0d ranked words never arrived", sb.pending());
            sb.fail_count++;
        end
        if (sb.fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ sim.f @@
design/sdstk_pkg.sv
design/sdstk_cfg.sv
design/sdstk_store.sv
design/stable_descending_sort_top_k_core.sv
tb/sv/sdstk_tb_pkg.sv
tb/sv/tb_top.sv
